[hdl/opmm_pkg.sv]
// shared types and codes for the order-preserving pattern matcher
`default_nettype none
package opmm_pkg;
	localparam int MAX_PATTERNS    = 2048;
	localparam int MAX_PATTERN_LEN = 32;
	localparam int QGRAM_SIZE      = 3;
	localparam int VALUE_BITS      = 16;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_HEADER = 2'd1,
		OP_ENTRY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_ACTIVE = 2'd0,
		CFG_WINLEN = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FP,
		ST_HREAD,
		ST_HCHK,
		ST_OREAD,
		ST_OWAIT,
		ST_OCHK,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[hdl/order_preserving_multi_pattern_match.sv]
// top level of the order-preserving multi-pattern matcher with q-gram filter
`default_nettype none
// Each text sample beat is shifted into a window of the last window_length
// values. Once the window is full, the q-gram fingerprint of its newest
// QGRAM_SIZE samples is built one sample per cycle, and then the pattern
// header memory is scanned over the active patterns, each pattern read,
// then compared. Every fingerprint hit walks that pattern's rank-order
// row in the order memory: the first entry is fetched, then one rank
// pair is compared per cycle until a pair fails or the clamped pattern
// length is reached. While the window is not yet full, the sample goes
// straight to its result. The next beat is taken in the cycle after the
// result is loaded. Load beats (pattern header and order entry) are written
// when accepted and give no result. The pattern memories are undefined until
// loaded. One result beat is produced per sample and held in an output
// register until taken, while the next beat may already be accepted; that
// next sample then waits at its end until the held result is gone.
// Configuration writes are allowed only while idle.
module order_preserving_multi_pattern_match (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  operation,
	input  wire  [15:0] text_value,
	input  wire  [10:0] pattern_index,
	input  wire  [12:0] pattern_fingerprint,
	input  wire  [5:0]  pattern_length,
	input  wire  [4:0]  entry_position,
	input  wire  [4:0]  entry_window_offset,
	input  wire         entry_equal_next,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        window_ready,
	output logic [11:0] window_matches,
	output logic [31:0] total_matches,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [11:0] cfg_data
);
	import opmm_pkg::*;

	localparam int PW = $clog2(MAX_PATTERNS);
	localparam int LW = $clog2(MAX_PATTERN_LEN);
	localparam int QW = $clog2(QGRAM_SIZE + 1);

	// configuration
	logic [11:0] active_q;
	logic [5:0]  winlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			winlen_q <= 6'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data;
				CFG_WINLEN: winlen_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// clamped window length and active count
	logic [6:0]  m_eff;
	logic [16:0] n_eff;
	always_comb begin
		m_eff = {1'b0, winlen_q};
		if (m_eff < 7'(QGRAM_SIZE)) m_eff = 7'(QGRAM_SIZE);
		if (m_eff > 7'(MAX_PATTERN_LEN)) m_eff = 7'(MAX_PATTERN_LEN);
		n_eff = {5'd0, active_q};
		if (n_eff > 17'(MAX_PATTERNS)) n_eff = 17'(MAX_PATTERNS);
	end

	// pattern memories: header holds {length, fingerprint}
	logic [18:0] hdr_mem [MAX_PATTERNS];
	logic [LW:0] ord_mem [MAX_PATTERNS*MAX_PATTERN_LEN];
	logic [18:0] hdr_s1;
	logic [12:0] hdr_fp_s1;
	logic [5:0]  hdr_len_s1;
	logic [LW:0] ord_rd_s1;
	assign hdr_fp_s1  = hdr_s1[12:0];
	assign hdr_len_s1 = hdr_s1[18:13];

	// text window: shift line, newest at the top
	logic [VALUE_BITS-1:0] win_q [MAX_PATTERN_LEN];
	logic [6:0]  seen_q;

	state_t state_q, state_d;
	logic [QW-1:0] qj_q;
	logic [12:0] fp_q;
	logic [12:0] fact_q;
	logic [16:0] pat_q;
	logic [LW:0] rank_q;
	logic [6:0]  plen_q;
	logic [LW:0] prev_q;
	logic        prev_eq_q;
	logic [11:0] wm_q;
	logic [31:0] tot_q;

	logic acc;
	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;

	// result register free to take the finished sample
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	// window value at offset o (0 = oldest)
	function automatic logic [VALUE_BITS-1:0] win_val(
		input logic [VALUE_BITS-1:0] w [MAX_PATTERN_LEN],
		input logic [6:0] m, input logic [LW-1:0] o);
		logic [6:0] idx;
		idx = 7'(MAX_PATTERN_LEN) - m + {2'b0, o};
		return w[idx[LW-1:0]];
	endfunction

	// fingerprint step: count of earlier q-gram samples <= current
	logic [LW-1:0] qbase;
	logic [VALUE_BITS-1:0] vj;
	logic [QW-1:0] cnt;
	always_comb begin
		qbase = LW'(m_eff - 7'(QGRAM_SIZE));
		vj = win_val(win_q, m_eff, qbase + LW'(qj_q));
		cnt = '0;
		for (int k = 0; k < QGRAM_SIZE; k++)
			if (QW'(k) < qj_q && win_val(win_q, m_eff, qbase + LW'(k)) <= vj)
				cnt = cnt + 1'b1;
	end

	// order pair compare
	logic [LW:0] cur_off;
	logic        cur_eq;
	logic        pair_ok;
	logic [VALUE_BITS-1:0] va, vb;
	always_comb begin
		cur_off = {1'b0, ord_rd_s1[LW-1:0]};
		cur_eq  = ord_rd_s1[LW];
		va = win_val(win_q, m_eff, prev_q[LW-1:0]);
		vb = win_val(win_q, m_eff, cur_off[LW-1:0]);
		pair_ok = (7'(prev_q) < m_eff) && (7'(cur_off) < m_eff) &&
			(prev_eq_q ? (va == vb) : (va < vb));
	end

	// while walking a row, fetch the entry after the current rank
	logic [LW-1:0] rank_rd;
	always_comb begin
		rank_rd = rank_q[LW-1:0];
		if (state_q == ST_OWAIT || state_q == ST_OCHK) rank_rd = rank_q[LW-1:0] + LW'(1);
	end

	logic [PW-1:0] hdr_addr;
	logic [PW+LW-1:0] ord_addr;
	assign hdr_addr = pat_q[PW-1:0];
	assign ord_addr = {pat_q[PW-1:0], rank_rd};

	always_ff @(posedge clk) begin
		if (acc && operation == OP_HEADER && {5'd0, pattern_index} < 16'(MAX_PATTERNS))
			hdr_mem[pattern_index[PW-1:0]] <= {pattern_length, pattern_fingerprint};
		if (acc && operation == OP_ENTRY && {5'd0, pattern_index} < 16'(MAX_PATTERNS) &&
		    {1'b0, entry_position} < 6'(MAX_PATTERN_LEN))
			ord_mem[{pattern_index[PW-1:0], entry_position[LW-1:0]}] <=
				{entry_equal_next, entry_window_offset[LW-1:0]};
		hdr_s1    <= hdr_mem[hdr_addr];
		ord_rd_s1 <= ord_mem[ord_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_LEN; i++) win_q[i] <= '0;
		end else if (acc && operation == OP_SAMPLE) begin
			for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) win_q[i] <= win_q[i+1];
			win_q[MAX_PATTERN_LEN-1] <= text_value[VALUE_BITS-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (acc && operation == OP_SAMPLE) state_d = ST_FP;
			ST_FP:    if (seen_q < m_eff) state_d = ST_OUT;
				else if (qj_q == QW'(QGRAM_SIZE - 1)) state_d = ST_HREAD;
			ST_HREAD: state_d = (pat_q >= n_eff) ? ST_OUT : ST_HCHK;
			ST_HCHK:  if (hdr_fp_s1 == fp_q) state_d = ST_OREAD;
				else state_d = ST_HREAD;
			ST_OREAD: state_d = ST_OWAIT;
			ST_OWAIT: state_d = (7'(rank_q) + 7'd1 >= plen_q) ? ST_HREAD : ST_OCHK;
			ST_OCHK:  state_d = (!pair_ok || 7'(rank_q) + 7'd1 >= plen_q) ?
				ST_HREAD : ST_OCHK;
			ST_OUT:   state_d = out_load ? ST_IDLE : ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	logic hit_now;
	always_comb begin
		hit_now = 1'b0;
		if (state_q == ST_OWAIT && 7'(rank_q) + 7'd1 >= plen_q) hit_now = 1'b1;
		if (state_q == ST_OCHK && pair_ok && 7'(rank_q) + 7'd1 >= plen_q) hit_now = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q <= '0; qj_q <= '0; fp_q <= '0; fact_q <= 13'd1;
			pat_q <= '0; rank_q <= '0; plen_q <= '0; prev_q <= '0; prev_eq_q <= 1'b0;
			wm_q <= '0; tot_q <= '0; out_valid <= 1'b0;
			window_ready <= 1'b0; window_matches <= '0; total_matches <= '0;
		end else begin
			state_q <= state_d;
			// a shrunk window pulls the sample count down
			if (acc && operation == OP_SAMPLE)
				seen_q <= (seen_q < m_eff) ? seen_q + 7'd1 : m_eff;
			else if (seen_q > m_eff)
				seen_q <= m_eff;
			if (out_load) begin
				out_valid <= 1'b1;
				window_ready <= (seen_q >= m_eff);
				window_matches <= wm_q;
				total_matches <= tot_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (acc && operation == OP_SAMPLE) begin
					qj_q <= '0; fp_q <= '0; fact_q <= 13'd1;
					pat_q <= '0; wm_q <= '0;
				end
				ST_FP: begin
					fp_q <= fp_q + 13'(cnt * fact_q);
					fact_q <= 13'(fact_q * (qj_q + 1'b1));
					qj_q <= qj_q + 1'b1;
				end
				ST_HREAD: ;
				ST_HCHK: begin
					plen_q <= ({1'b0, hdr_len_s1} > m_eff) ? m_eff : {1'b0, hdr_len_s1};
					rank_q <= '0;
					if (hdr_fp_s1 != fp_q) pat_q <= pat_q + 17'd1;
				end
				ST_OREAD: ;
				ST_OWAIT: begin
					prev_q <= cur_off; prev_eq_q <= cur_eq;
					rank_q <= rank_q + 1'b1;
					if (hit_now) pat_q <= pat_q + 17'd1;
				end
				ST_OCHK: begin
					prev_q <= cur_off; prev_eq_q <= cur_eq;
					if (!pair_ok || 7'(rank_q) + 7'd1 >= plen_q) pat_q <= pat_q + 17'd1;
					else rank_q <= rank_q + 1'b1;
				end
				ST_OUT: ;
				default: ;
			endcase
			if (hit_now) begin
				if (wm_q != 12'hFFF) wm_q <= wm_q + 12'd1;
				if (tot_q != 32'hFFFF_FFFF) tot_q <= tot_q + 32'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(total_matches) && $stable(window_matches))
		else $error("result changed while waiting");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("accepted while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid && !out_ready |=> state_q == ST_OUT)
		else $error("result overwritten");
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// testbench for the order-preserving multi-pattern matcher: random loads, samples and configs
`timescale 1ns / 100ps
module tb_top;
	import opmm_pkg::*;

	localparam int NPAT = 2048;
	localparam int PLEN = 32;
	localparam int QG   = 3;

	// one input beat, every field as the block sees it
	typedef struct {
		op_t         op;
		logic [15:0] value;
		logic [10:0] slot;
		logic [12:0] fprint;
		logic [5:0]  plen;
		logic [4:0]  pos;
		logic [4:0]  offs;
		logic        eqn;
	} beat_t;

	// one result beat
	typedef struct {
		logic        ready;
		logic [11:0] hits;
		logic [31:0] total;
	} match_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [15:0] text_value = '0;
	logic [10:0] pattern_index = '0;
	logic [12:0] pattern_fingerprint = '0;
	logic [5:0]  pattern_length = '0;
	logic [4:0]  entry_position = '0;
	logic [4:0]  entry_window_offset = '0;
	logic        entry_equal_next = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        window_ready;
	logic [11:0] window_matches;
	logic [31:0] total_matches;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	order_preserving_multi_pattern_match dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mirror of the matcher state
	logic [15:0] win_mirror [PLEN];
	int unsigned seen_cnt;
	logic [12:0] fp_mirror  [NPAT];
	logic [5:0]  len_mirror [NPAT];
	logic [4:0]  offs_mirror[NPAT][PLEN];
	logic        eq_mirror  [NPAT][PLEN];
	logic [31:0] total_mirror;
	int unsigned active_cfg;
	int unsigned winlen_cfg;

	beat_t  pending_beats[$];
	match_t expected_matches[$];
	int     error_count = 0;
	int     hold_cycles = 0;
	bit     no_idle = 0;
	int     tx_gap = 0;
	int     rx_wait = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// clamp of the window register into the legal window sizes
	function automatic int unsigned win_size();
		if (winlen_cfg < QG) return QG;
		if (winlen_cfg > PLEN) return PLEN;
		return winlen_cfg;
	endfunction

	function automatic logic [15:0] win_at(int unsigned m, int unsigned o);
		return win_mirror[PLEN - m + o];
	endfunction

	// rank-count fingerprint of the newest q samples
	function automatic int unsigned qgram_code(int unsigned m);
		int unsigned fp = 0, fact = 1, cnt;
		for (int j = 0; j < QG; j++) begin
			cnt = 0;
			if (j > 0) fact *= j;
			for (int k = 0; k < j; k++)
				if (win_at(m, m - QG + k) <= win_at(m, m - QG + j)) cnt++;
			fp += cnt * fact;
		end
		return fp;
	endfunction

	// walk the rank-order row of one pattern against the window
	function automatic bit order_fits(int unsigned m, int unsigned p);
		int unsigned len = len_mirror[p];
		int unsigned oa, ob;
		if (len > m) len = m;
		for (int r = 0; r + 1 < len; r++) begin
			oa = offs_mirror[p][r];
			ob = offs_mirror[p][r + 1];
			if (oa >= m || ob >= m) return 1'b0;
			if (eq_mirror[p][r]) begin
				if (win_at(m, oa) != win_at(m, ob)) return 1'b0;
			end else begin
				if (win_at(m, oa) >= win_at(m, ob)) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// apply one accepted beat to the mirror, queue the result it causes
	task automatic track_beat(input beat_t b);
		match_t r;
		int unsigned m, fp, n;
		case (b.op)
			OP_HEADER: begin
				fp_mirror[b.slot] = b.fprint;
				len_mirror[b.slot] = b.plen;
			end
			OP_ENTRY: begin
				offs_mirror[b.slot][b.pos] = b.offs;
				eq_mirror[b.slot][b.pos] = b.eqn;
			end
			OP_SAMPLE: begin
				m = win_size();
				for (int i = 0; i < PLEN - 1; i++) win_mirror[i] = win_mirror[i + 1];
				win_mirror[PLEN - 1] = b.value;
				if (seen_cnt < m) seen_cnt++;
				if (seen_cnt > m) seen_cnt = m;
				r.ready = (seen_cnt >= m);
				r.hits = '0;
				if (r.ready) begin
					fp = qgram_code(m);
					n = (active_cfg > NPAT) ? NPAT : active_cfg;
					for (int p = 0; p < n; p++)
						if (fp_mirror[p] == fp && order_fits(m, p)) begin
							if (r.hits != 12'hfff) r.hits++;
							if (total_mirror != 32'hffff_ffff) total_mirror++;
						end
				end
				r.total = total_mirror;
				expected_matches.push_back(r);
			end
			default: ;
		endcase
	endtask

	// sender: a fresh beat goes out once the drawn gap has run down
	always @(posedge clk) begin
		beat_t b;
		logic  v_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			v_next = in_valid;
			if (in_valid && in_ready) begin
				track_beat('{op_t'(operation), text_value, pattern_index, pattern_fingerprint,
					pattern_length, entry_position, entry_window_offset, entry_equal_next});
				tx_gap = draw_wait();
				v_next = 1'b0;
			end
			if (!v_next) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_beats.size() > 0) begin
					b = pending_beats.pop_front();
					operation           <= b.op;
					text_value          <= b.value;
					pattern_index       <= b.slot;
					pattern_fingerprint <= b.fprint;
					pattern_length      <= b.plen;
					entry_position      <= b.pos;
					entry_window_offset <= b.offs;
					entry_equal_next    <= b.eqn;
					v_next = 1'b1;
				end
			end
			in_valid <= v_next;
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk)
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

	// receiver: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		match_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					e = expected_matches.pop_front();
					if (window_ready !== e.ready)
						report($sformatf("window_ready %b, want %b", window_ready, e.ready));
					if (window_matches !== e.hits)
						report($sformatf("window_matches %0d, want %0d", window_matches, e.hits));
					if (total_matches !== e.total)
						report($sformatf("total_matches %0d, want %0d", total_matches, e.total));
				end
				rx_wait = draw_wait();
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0) && (hold_cycles == 0);
		end
	end

	// configuration write, only ever issued while the block is idle
	task automatic write_cfg(input cfg_idx_t idx, input logic [11:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACTIVE) active_cfg = {20'd0, data};
		else winlen_cfg = {26'd0, data[5:0]};
	endtask

	// wait until every beat is sent and every result has come back
	task automatic drain();
		while (pending_beats.size() > 0 || in_valid || expected_matches.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic beat_t sample_beat(input logic [15:0] v);
		beat_t b = '{OP_SAMPLE, v, 11'($urandom), 13'($urandom), 6'($urandom),
			5'($urandom), 5'($urandom), 1'($urandom)};
		return b;
	endfunction

	task automatic push_header(input int slot, input int fp, input int len);
		beat_t b = '{OP_HEADER, 16'($urandom), 11'(slot), 13'(fp), 6'(len),
			5'($urandom), 5'($urandom), 1'($urandom)};
		pending_beats.push_back(b);
	endtask

	task automatic push_entry(input int slot, input int pos, input int offs, input bit eqn);
		beat_t b = '{OP_ENTRY, 16'($urandom), 11'(slot), 13'($urandom), 6'($urandom),
			5'(pos), 5'(offs), eqn};
		pending_beats.push_back(b);
	endtask

	// a random pattern in one slot, with its whole rank row loaded
	task automatic load_pattern(input int slot, input int m);
		int fp, len, base;
		fp = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(0, 8191);
		case ($urandom_range(0, 7))
			0: len = $urandom_range(0, 1);
			1: len = PLEN;
			2: len = $urandom_range(0, 63) % 33;
			default: len = $urandom_range(2, 4);
		endcase
		push_header(slot, fp, len);
		base = (len < m) ? m - len : 0;
		for (int p = 0; p < len; p++) begin
			// mostly offsets among the newest samples, now and then anywhere
			if ($urandom_range(0, 5) == 0)
				push_entry(slot, p, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
			else
				push_entry(slot, p, $urandom_range(base, m - 1), $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic push_samples(input int count);
		int span = $urandom_range(0, 2);
		for (int i = 0; i < count; i++)
			case (span)
				0: pending_beats.push_back(sample_beat(16'($urandom_range(0, 3))));
				1: pending_beats.push_back(sample_beat(16'($urandom_range(0, 15))));
				default: pending_beats.push_back(sample_beat(16'($urandom)));
			endcase
	endtask

	initial begin
		beat_t stray;
		int m, n;
		int win_choice [5] = '{3, 32, 0, 63, 8};

		for (int i = 0; i < PLEN; i++) win_mirror[i] = '0;
		seen_cnt = 0;
		total_mirror = '0;
		active_cfg = 0;
		winlen_cfg = 8;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: filling window at reset defaults, value extremes, unknown op
		pending_beats.push_back(sample_beat(16'h0000));
		pending_beats.push_back(sample_beat(16'hffff));
		stray = sample_beat(16'h1234);
		stray.op = OP_NONE;
		pending_beats.push_back(stray);
		for (int i = 0; i < 7; i++) pending_beats.push_back(sample_beat(16'($urandom)));
		// hand-built patterns: length 0 and 1 always match on a fingerprint hit,
		// rising and equal rows, and a row pointing outside the window
		push_header(0, 0, 0);
		push_header(1, 5, 1);
		push_header(2, 5, 3);
		for (int p = 0; p < 3; p++) push_entry(2, p, p, 1'b0);
		push_header(3, 5, 5);
		for (int p = 0; p < 5; p++) push_entry(3, p, 31 - p, 1'b1);
		push_header(4, 5, 3);
		for (int p = 0; p < 3; p++) push_entry(4, p, p, 1'b1);
		drain();
		write_cfg(CFG_ACTIVE, 12'd5);
		write_cfg(CFG_WINLEN, 12'd3);
		pending_beats.push_back(sample_beat(16'd1));
		pending_beats.push_back(sample_beat(16'd2));
		pending_beats.push_back(sample_beat(16'd3));
		pending_beats.push_back(sample_beat(16'd3));
		pending_beats.push_back(sample_beat(16'd3));
		pending_beats.push_back(sample_beat(16'd3));
		pending_beats.push_back(sample_beat(16'd2));
		pending_beats.push_back(sample_beat(16'd1));
		// window grown past the samples seen, then shrunk below them
		drain();
		write_cfg(CFG_WINLEN, 12'd32);
		push_samples(4);
		drain();
		write_cfg(CFG_WINLEN, 12'd3);
		push_samples(3);

		// random phases over several window sizes and pattern counts
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			no_idle = (ph == 2);
			write_cfg(CFG_WINLEN, 12'((ph < 5) ? win_choice[ph] : $urandom_range(0, 63)));
			m = win_size();
			n = $urandom_range(1, 4);
			for (int s = 0; s < n; s++) load_pattern(s, m);
			drain();
			write_cfg(CFG_ACTIVE, 12'((ph == 5) ? 0 : n));
			if (ph == 4) begin
				// receiver stalls while samples keep coming in
				@(negedge clk) hold_cycles = 300;
			end
			push_samples(18);
		end
		drain();
		no_idle = 0;

		if (expected_matches.size() != 0) report("results still expected at the end");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
